// ===== design/dadw_pkg.sv =====
// Types, constants and calendar functions for the date-plus-days unit.
// Used by the controller, the datapath and the top level.
`default_nettype none
package dadw_pkg;

	localparam int unsigned YEAR_W = 17;
	localparam int unsigned REST_W = 21;
	localparam int unsigned STEP_W = 2;
	localparam logic [STEP_W-1:0] STEP_FOLD_WIDE = 2'd2;
	localparam logic [STEP_W-1:0] STEP_FOLD_NARROW = 2'd1;
	localparam logic [STEP_W-1:0] STEP_LAST = 2'd0;
	localparam logic [10:0] CYCLE_RECIP = 11'd1311;
	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_DEC = 4'd12;
	localparam logic [15:0] CYCLE_LAST = 16'd399;
	localparam logic [15:0] CENTURY = 16'd100;
	localparam logic [REST_W-1:0] WEEK_DAYS = 21'd7;
	localparam logic [REST_W-1:0] YEAR_DAYS = 21'd365;
	localparam logic [REST_W-1:0] LEAP_YEAR_DAYS = 21'd366;
	localparam logic [REST_W-1:0] DEC_LAST_DAY = 21'd31;

	typedef struct packed {
		logic [15:0] start_year;
		logic [3:0]  start_month;
		logic [4:0]  start_day;
		logic [2:0]  start_weekday;
		logic [19:0] days_to_add;
	} in_t;

	typedef struct packed {
		logic [15:0] end_year;
		logic [3:0]  end_month;
		logic [4:0]  end_day;
		logic [2:0]  end_weekday;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_FOLD,
		ST_YEAR,
		ST_MONTH,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic reduce;
		logic fold;
		logic year_step;
		logic fix_zero;
		logic month_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic reduce_last;
		logic year_more;
		logic rest_zero;
		logic month_more;
		logic out_busy;
	} sts_t;

	function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mo);
		logic [4:0] len;
		case (mo)
			4'd2: len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	function automatic logic [8:0] days_before(input logic leap, input logic [3:0] mo);
		logic [8:0] base;
		case (mo)
			4'd1: base = 9'd0;
			4'd2: base = 9'd31;
			4'd3: base = 9'd59;
			4'd4: base = 9'd90;
			4'd5: base = 9'd120;
			4'd6: base = 9'd151;
			4'd7: base = 9'd181;
			4'd8: base = 9'd212;
			4'd9: base = 9'd243;
			4'd10: base = 9'd273;
			4'd11: base = 9'd304;
			4'd12: base = 9'd334;
			default: base = 9'd0;
		endcase
		return base + ((leap && mo > 4'd2) ? 9'd1 : 9'd0);
	endfunction

	function automatic logic leap_of_cycle(input logic [15:0] pos);
		return (pos[1:0] == 2'd0) && (pos != CENTURY) && (pos != 16'd200)
			&& (pos != 16'd300);
	endfunction

endpackage
`default_nettype wire

// ===== design/date_add_days_weekday_unit.sv =====
// A request is reduced, folded into a day count within its start year, stepped one
// whole year per cycle and then month by month, and its result is registered once
// the output is free.
// One request at a time; the unit is back in idle as soon as the result is
// registered, so the next is taken even while that result still waits at the output.
// Reset (arst_n low, asynchronous) returns to idle and drops any result.
`default_nettype none
module date_add_days_weekday_unit import dadw_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  in_t       in_data,
	output logic      out_valid,
	input  wire logic out_stall,
	output out_t      out_data
);

	cmd_t cmd;
	sts_t sts;

	dadw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	dadw_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// ===== design/dadw_ctrl.sv =====
// Controller state machine for the date-plus-days unit.
// Depends on dadw_pkg; drives commands into dadw_dpath and reads its status.
`default_nettype none
module dadw_ctrl import dadw_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  sts_t      sts,
	output cmd_t      cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				cmd.reduce = 1'b1;
				if (sts.reduce_last) state_d = ST_FOLD;
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				state_d = ST_YEAR;
			end
			ST_YEAR: begin
				if (sts.year_more) begin
					cmd.year_step = 1'b1;
				end else if (sts.rest_zero) begin
					cmd.fix_zero = 1'b1;
					state_d = ST_FINISH;
				end else begin
					state_d = ST_MONTH;
				end
			end
			ST_MONTH: begin
				if (sts.month_more) cmd.month_step = 1'b1;
				else state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ===== design/dadw_dpath.sv =====
// Datapath for the date-plus-days unit: mod-7 and mod-400 reduction,
// year and month stepping, and the result register. Depends on dadw_pkg.
`default_nettype none
module dadw_dpath import dadw_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  in_t       in_data,
	input  cmd_t      cmd,
	output sts_t      sts,
	input  wire logic out_stall,
	output logic      out_valid,
	output out_t      out_data
);

	logic [YEAR_W-1:0] year_q;
	logic [15:0]       cyc_q;
	logic [7:0]        quo_q;
	logic [REST_W-1:0] rest_q;
	logic [REST_W-1:0] wk_q;
	logic [STEP_W-1:0] step_q;
	logic [3:0]        month_q;
	logic [4:0]        day_q;
	logic [19:0]       add_q;
	logic              out_valid_q;
	out_t              out_q;

	logic              leap;
	logic [REST_W-1:0] wk_fold;
	logic [22:0]       cyc_prod;
	logic [11:0]       quo_x25;
	logic [11:0]       cyc_sub;
	logic [REST_W-1:0] year_len;
	logic [REST_W-1:0] mon_len;
	logic [3:0]        mo_clamp;

	assign leap = leap_of_cycle(cyc_q);
	assign wk_fold = REST_W'(wk_q[2:0]) + REST_W'(wk_q[5:3]) + REST_W'(wk_q[8:6])
		+ REST_W'(wk_q[11:9]) + REST_W'(wk_q[14:12]) + REST_W'(wk_q[17:15])
		+ REST_W'(wk_q[20:18]);
	assign cyc_prod = cyc_q[15:4] * CYCLE_RECIP;
	assign quo_x25 = {quo_q, 4'b0} + {1'b0, quo_q, 3'b0} + {4'b0, quo_q};
	assign cyc_sub = cyc_q[15:4] - quo_x25;
	assign year_len = leap ? LEAP_YEAR_DAYS : YEAR_DAYS;
	assign mon_len = REST_W'(month_len(leap, month_q));
	assign mo_clamp = (in_data.start_month == 4'd0) ? MONTH_JAN :
		(in_data.start_month > MONTH_DEC) ? MONTH_DEC : in_data.start_month;

	assign sts.reduce_last = (step_q == STEP_LAST);
	assign sts.year_more = (rest_q >= year_len);
	assign sts.rest_zero = (rest_q == '0);
	assign sts.month_more = (month_q < MONTH_DEC) && (rest_q > mon_len);
	assign sts.out_busy = out_valid_q && out_stall;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			year_q <= {1'b0, in_data.start_year};
			cyc_q <= in_data.start_year;
			wk_q <= REST_W'(in_data.days_to_add) + REST_W'(in_data.start_weekday);
			step_q <= STEP_FOLD_WIDE;
			month_q <= mo_clamp;
			day_q <= in_data.start_day;
			add_q <= in_data.days_to_add;
		end
		if (cmd.reduce) begin
			case (step_q)
				STEP_FOLD_WIDE: begin
					wk_q <= wk_fold;
					quo_q <= cyc_prod[22:15];
				end
				STEP_FOLD_NARROW: begin
					wk_q <= wk_fold;
					cyc_q <= {7'd0, cyc_sub[4:0], cyc_q[3:0]};
				end
				default: begin
					if (wk_q >= WEEK_DAYS) wk_q <= wk_q - WEEK_DAYS;
				end
			endcase
			if (step_q != STEP_LAST) step_q <= step_q - 1'b1;
		end
		if (cmd.fold) begin
			rest_q <= REST_W'(add_q) + REST_W'(day_q) + REST_W'(days_before(leap, month_q));
			month_q <= MONTH_JAN;
		end
		if (cmd.year_step) begin
			rest_q <= rest_q - year_len;
			year_q <= year_q + 1'b1;
			cyc_q <= (cyc_q == CYCLE_LAST) ? '0 : cyc_q + 1'b1;
		end
		if (cmd.fix_zero) begin
			year_q <= year_q - 1'b1;
			month_q <= MONTH_DEC;
			rest_q <= DEC_LAST_DAY;
		end
		if (cmd.month_step) begin
			rest_q <= rest_q - mon_len;
			month_q <= month_q + 1'b1;
		end
		if (cmd.emit) begin
			out_q.end_year <= year_q[15:0];
			out_q.end_month <= month_q;
			out_q.end_day <= rest_q[4:0];
			out_q.end_weekday <= wk_q[2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
`default_nettype wire

// ===== tb/date_add_days_weekday_unit_tb.sv =====
`timescale 1ns / 100ps
// Testbench for date_add_days_weekday_unit: directed and random date requests,
// results checked against an in-bench calendar predictor. Depends on dadw_pkg.
module date_add_days_weekday_unit_tb;
	import dadw_pkg::*;

	localparam int unsigned RANDOM_REQUESTS = 200;
	localparam int unsigned MAX_WAIT = 12;
	localparam int unsigned IDLE_LIMIT = 16000;
	localparam int unsigned TAIL_CYCLES = 64;
	localparam int unsigned PRINT_CAP = 100;

	typedef struct {
		in_t rq;
		bit  drain;
	} pend_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t  in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;

	pend_t pending_requests[$];
	out_t  expected_dates[$];
	int unsigned mismatches = 0;
	int unsigned n_req_taken = 0;
	int unsigned n_req_sent = 0;
	int unsigned n_res_taken = 0;
	int unsigned n_res_seen = 0;
	int unsigned send_gap = 0;
	int unsigned send_calm = 0;
	int unsigned stall_left = 0;
	int unsigned stall_calm = 0;
	int unsigned idle_cycles = 0;

	date_add_days_weekday_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	function automatic bit is_leap(input int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int unsigned days_in(input bit lp, input int unsigned m);
		case (m)
			2: return lp ? 29 : 28;
			4, 6, 9, 11: return 30;
			default: return 31;
		endcase
	endfunction

	function automatic out_t date_after(input in_t rq);
		int unsigned yr;
		int unsigned mo;
		int unsigned m;
		int unsigned rest;
		int unsigned wd_sum;
		bit lp;
		out_t r;
		yr = rq.start_year;
		mo = rq.start_month;
		if (mo == 0) mo = 1;
		if (mo > 12) mo = 12;
		lp = is_leap(yr);
		rest = rq.days_to_add;
		rest = rest + rq.start_day;
		for (m = 1; m < mo; m++) rest = rest + days_in(lp, m);
		while (rest >= (lp ? 366 : 365)) begin
			rest = rest - (lp ? 366 : 365);
			yr = yr + 1;
			lp = is_leap(yr);
		end
		if (rest == 0) begin
			yr = yr - 1;
			r.end_month = 4'd12;
			r.end_day = 5'd31;
		end else begin
			m = 1;
			while (m < 12 && rest > days_in(lp, m)) begin
				rest = rest - days_in(lp, m);
				m = m + 1;
			end
			r.end_month = 4'(m);
			r.end_day = 5'(rest);
		end
		r.end_year = 16'(yr);
		wd_sum = rq.start_weekday;
		wd_sum = wd_sum + rq.days_to_add;
		r.end_weekday = 3'(wd_sum % 7);
		return r;
	endfunction

	function automatic in_t random_date_request();
		in_t rq;
		int unsigned y;
		case ($urandom_range(0, 4))
			0: y = 100 * $urandom_range(0, 655) + $urandom_range(0, 4);
			1: y = $urandom_range(62000, 65535);
			2: y = $urandom_range(1, 2400);
			default: y = $urandom_range(0, 65535);
		endcase
		rq.start_year = 16'(y);
		if ($urandom_range(0, 6) == 0) rq.start_month = 4'($urandom_range(0, 15));
		else rq.start_month = 4'($urandom_range(1, 12));
		if ($urandom_range(0, 6) == 0) rq.start_day = 5'($urandom_range(0, 31));
		else if (rq.start_month >= 1 && rq.start_month <= 12)
			rq.start_day = 5'($urandom_range(1, days_in(is_leap(y), rq.start_month)));
		else rq.start_day = 5'($urandom_range(1, 31));
		if ($urandom_range(0, 9) == 0) rq.start_weekday = 3'd7;
		else rq.start_weekday = 3'($urandom_range(0, 6));
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: rq.days_to_add = 20'($urandom_range(0, 1500));
			5, 6, 7: rq.days_to_add = 20'($urandom_range(0, 65535));
			default: rq.days_to_add = 20'($urandom_range(0, 1048575));
		endcase
		return rq;
	endfunction

	task automatic queue_request(input in_t rq, input bit drain);
		pend_t p;
		p.rq = rq;
		p.drain = drain;
		pending_requests.push_back(p);
	endtask

	task automatic add_date(input int unsigned y, input int unsigned m, input int unsigned d,
			input int unsigned w, input int unsigned a);
		in_t rq;
		rq.start_year = 16'(y);
		rq.start_month = 4'(m);
		rq.start_day = 5'(d);
		rq.start_weekday = 3'(w);
		rq.days_to_add = 20'(a);
		queue_request(rq, 1'b0);
	endtask

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	initial begin
		forever #4 clk = ~clk;
	end

	always @(negedge clk) begin
		logic nv;
		in_t nd;
		pend_t nx;
		nv = in_valid;
		nd = in_data;
		if (arst_n) begin
			if (in_valid && n_req_taken != n_req_sent) begin
				n_req_sent++;
				nv = 1'b0;
			end
			if (!nv) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_requests.size() > 0
						&& !(pending_requests[0].drain && expected_dates.size() > 0)) begin
					nx = pending_requests.pop_front();
					nd = nx.rq;
					nv = 1'b1;
					if (send_calm > 0) begin
						send_calm--;
						send_gap = 0;
					end else begin
						send_gap = $urandom_range(0, MAX_WAIT);
						if ($urandom_range(0, 7) == 0) send_calm = $urandom_range(4, 16);
					end
				end
			end
		end
		in_valid <= nv;
		in_data <= nd;
	end

	always @(negedge clk) begin
		if (n_res_taken != n_res_seen) begin
			n_res_seen = n_res_taken;
			if (stall_calm > 0) begin
				stall_calm--;
				stall_left = 0;
			end else begin
				stall_left = $urandom_range(0, MAX_WAIT);
				if ($urandom_range(0, 7) == 0) stall_calm = $urandom_range(4, 16);
			end
		end else if (out_valid && stall_left > 0) begin
			stall_left--;
		end
		out_stall <= (stall_left > 0);
	end

	always @(posedge clk) begin
		out_t want;
		if (out_valid && !out_stall) begin
			n_res_taken++;
			if (expected_dates.size() == 0) begin
				report_mismatch("result with no request pending", out_data.end_year, 0);
			end else begin
				want = expected_dates.pop_front();
				if (out_data.end_year !== want.end_year)
					report_mismatch("end_year", out_data.end_year, want.end_year);
				if (out_data.end_month !== want.end_month)
					report_mismatch("end_month", out_data.end_month, want.end_month);
				if (out_data.end_day !== want.end_day)
					report_mismatch("end_day", out_data.end_day, want.end_day);
				if (out_data.end_weekday !== want.end_weekday)
					report_mismatch("end_weekday", out_data.end_weekday, want.end_weekday);
			end
		end
		if (in_valid && !in_stall) begin
			expected_dates.push_back(date_after(in_data));
			n_req_taken++;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("** date_add_days_weekday_unit: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		add_date(1, 1, 1, 0, 0);
		add_date(65535, 15, 31, 7, 1048575);
		add_date(2000, 1, 0, 3, 0);
		add_date(0, 1, 0, 5, 0);
		add_date(0, 1, 1, 0, 366);
		add_date(400, 1, 0, 0, 0);
		add_date(2023, 0, 15, 2, 10);
		add_date(2023, 13, 5, 4, 30);
		add_date(2023, 15, 31, 1, 1);
		add_date(2023, 2, 31, 6, 0);
		add_date(2024, 2, 28, 3, 1);
		add_date(1900, 2, 28, 3, 1);
		add_date(2000, 2, 28, 1, 1);
		add_date(2100, 2, 28, 0, 1);
		add_date(1999, 12, 31, 5, 1);
		add_date(2000, 1, 1, 6, 146097);
		add_date(2020, 3, 1, 7, 0);
		add_date(1, 1, 1, 7, 6);
		add_date(65535, 12, 31, 3, 1);
		add_date(60000, 6, 15, 2, 1048575);
		add_date(1, 1, 1, 0, 1048575);
		add_date(2023, 12, 31, 0, 365);
		for (int i = 0; i < RANDOM_REQUESTS; i++)
			queue_request(random_date_request(), (i == 0) || ($urandom_range(0, 24) == 0));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		do @(posedge clk);
		while (!(pending_requests.size() == 0 && !in_valid && expected_dates.size() == 0));
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("** date_add_days_weekday_unit: PASSED **");
		else
			$display("** date_add_days_weekday_unit: FAILED **");
		$finish;
	end

endmodule

// ===== date_add_days_weekday_unit.f =====
design/dadw_pkg.sv
design/dadw_ctrl.sv
design/dadw_dpath.sv
design/date_add_days_weekday_unit.sv
tb/date_add_days_weekday_unit_tb.sv
